/* rtl/rgb_to_ycbcr420_p010_top_defines.svh */
// Assertion macros for the RGB to YCbCr 4:2:0 P010 converter.
// Taken in by the modules that carry concurrent assertions; no dependencies.
`ifndef RGB_TO_YCBCR420_P010_TOP_DEFINES_SVH
`define RGB_TO_YCBCR420_P010_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RYC420_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ryc420 assertion failed");

// next-cycle implication, checked out of reset
`define RYC420_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ryc420 assertion failed");

`endif

/* rtl/ryc420_pkg.sv */
// Shared types and constants for the RGB to YCbCr 4:2:0 P010 converter.
// No dependencies; used by the lane, merge and top-level modules.
`timescale 1ns / 1ps

package ryc420_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CompW     = 16;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned ProdW     = CompW + CoefW;
  localparam int unsigned ChromaW   = ProdW + 2;
  localparam int unsigned ChromaSumW = ChromaW + 3;
  localparam int unsigned CodeW     = 10;

  localparam logic [CoefW-1:0] KyR  = 16'd19595;
  localparam logic [CoefW-1:0] KyG  = 16'd38470;
  localparam logic [CoefW-1:0] KyB  = 16'd7471;
  localparam logic [CoefW-1:0] KcbR = 16'd11058;
  localparam logic [CoefW-1:0] KcbG = 16'd21710;
  localparam logic [CoefW-1:0] KcbB = 16'd32768;
  localparam logic [CoefW-1:0] KcrR = 16'd32768;
  localparam logic [CoefW-1:0] KcrG = 16'd27439;
  localparam logic [CoefW-1:0] KcrB = 16'd5329;

  // 65535*1024/2047 in Q18 plus half an LSB of the Q18 -> word step
  localparam logic signed [ChromaSumW-1:0] ChromaOfsRnd = 37'sd8594130871;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  typedef struct packed {
    logic [CodeW-1:0]          luma;
    logic signed [ChromaW-1:0] cb;
    logic signed [ChromaW-1:0] cr;
  } lane_out_t;

endpackage

/* rtl/ryc420_lane.sv */
// One pixel lane: nine coefficient products, then luma code and Cb/Cr sums.
// Depends on ryc420_pkg.
`timescale 1ns / 1ps

module ryc420_lane (
  input  logic                                clk_i,
  input  ryc420_pkg::stage_en_t               en_i,
  input  logic [ryc420_pkg::CompW-1:0]        red_i,
  input  logic [ryc420_pkg::CompW-1:0]        green_i,
  input  logic [ryc420_pkg::CompW-1:0]        blue_i,
  output ryc420_pkg::lane_out_t               lane_o
);
  import ryc420_pkg::*;

  logic [ProdW-1:0] py_r_q, py_g_q, py_b_q;
  logic [ProdW-1:0] pcb_r_q, pcb_g_q, pcb_b_q;
  logic [ProdW-1:0] pcr_r_q, pcr_g_q, pcr_b_q;

  logic [ProdW:0]            luma_acc;
  logic signed [ChromaW-1:0] cb_d, cr_d;
  lane_out_t                 lane_d, lane_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      py_r_q  <= KyR  * red_i;
      py_g_q  <= KyG  * green_i;
      py_b_q  <= KyB  * blue_i;
      pcb_r_q <= KcbR * red_i;
      pcb_g_q <= KcbG * green_i;
      pcb_b_q <= KcbB * blue_i;
      pcr_r_q <= KcrR * red_i;
      pcr_g_q <= KcrG * green_i;
      pcr_b_q <= KcrB * blue_i;
    end
  end

  // luma word never exceeds 65535, so the code is a plain slice
  always_comb begin
    luma_acc = {1'b0, py_r_q} + {1'b0, py_g_q} + {1'b0, py_b_q}
             + (ProdW+1)'(32768);
    cb_d = $signed({2'b00, pcb_b_q}) - $signed({2'b00, pcb_r_q})
         - $signed({2'b00, pcb_g_q});
    cr_d = $signed({2'b00, pcr_r_q}) - $signed({2'b00, pcr_g_q})
         - $signed({2'b00, pcr_b_q});
    lane_d.luma = luma_acc[ProdW-1:ProdW-CodeW];
    lane_d.cb   = cb_d;
    lane_d.cr   = cr_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

/* rtl/ryc420_merge.sv */
// Merge stage: averages lane chroma, adds offset, rounds and clamps; holds result.
// Depends on ryc420_pkg.
`timescale 1ns / 1ps

module ryc420_merge (
  input  logic                                       clk_i,
  input  logic                                       en_i,
  input  ryc420_pkg::lane_out_t [ryc420_pkg::NumLanes-1:0] lanes_i,
  output logic [ryc420_pkg::NumLanes-1:0][ryc420_pkg::CodeW-1:0] luma_o,
  output logic [ryc420_pkg::CodeW-1:0]               cb_code_o,
  output logic [ryc420_pkg::CodeW-1:0]               cr_code_o
);
  import ryc420_pkg::*;

  logic signed [ChromaSumW-1:0] cb_sum, cr_sum;
  logic [CodeW-1:0] cb_code_d, cr_code_d;
  logic [NumLanes-1:0][CodeW-1:0] luma_q;
  logic [CodeW-1:0] cb_code_q, cr_code_q;

  function automatic logic [CodeW-1:0] to_code(input logic signed [ChromaSumW-1:0] v);
    logic [CodeW-1:0] c;
    c = v[33:24];
    if (v[ChromaSumW-1]) begin
      c = '0;
    end else if (|v[ChromaSumW-2:34]) begin
      c = '1;
    end
    return c;
  endfunction

  always_comb begin
    cb_sum = ChromaOfsRnd;
    cr_sum = ChromaOfsRnd;
    for (int l = 0; l < NumLanes; l++) begin
      cb_sum = cb_sum + ChromaSumW'(lanes_i[l].cb);
      cr_sum = cr_sum + ChromaSumW'(lanes_i[l].cr);
    end
    cb_code_d = to_code(cb_sum);
    cr_code_d = to_code(cr_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NumLanes; l++) begin
        luma_q[l] <= lanes_i[l].luma;
      end
      cb_code_q <= cb_code_d;
      cr_code_q <= cr_code_d;
    end
  end

  assign luma_o    = luma_q;
  assign cb_code_o = cb_code_q;
  assign cr_code_o = cr_code_q;

endmodule

/* rtl/rgb_to_ycbcr420_p010_top.sv */
// Registered stages in order: products, lane sums, merge.
// Throughput: one 2x2 block per cycle unless the output is held; four pixel lanes, 9 multipliers each.
// Each stage advances when empty or when the next one advances, so a held
// output still lets the earlier stages fill. Reset clears the stage valid flags only.
// Depends on ryc420_pkg, ryc420_lane, ryc420_merge and the defines header.
`timescale 1ns / 1ps
`include "rgb_to_ycbcr420_p010_top_defines.svh"

module rgb_to_ycbcr420_p010_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] red_top_left_i,
  input  logic [15:0] green_top_left_i,
  input  logic [15:0] blue_top_left_i,
  input  logic [15:0] red_bottom_left_i,
  input  logic [15:0] green_bottom_left_i,
  input  logic [15:0] blue_bottom_left_i,
  input  logic [15:0] red_top_right_i,
  input  logic [15:0] green_top_right_i,
  input  logic [15:0] blue_top_right_i,
  input  logic [15:0] red_bottom_right_i,
  input  logic [15:0] green_bottom_right_i,
  input  logic [15:0] blue_bottom_right_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  luma_top_left_o,
  output logic [9:0]  luma_bottom_left_o,
  output logic [9:0]  luma_top_right_o,
  output logic [9:0]  luma_bottom_right_o,
  output logic [9:0]  blue_chroma_o,
  output logic [9:0]  red_chroma_o
);
  import ryc420_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  stage_en_t lane_en;

  logic [NumLanes-1:0][CompW-1:0] red, green, blue;
  lane_out_t [NumLanes-1:0] lanes;
  logic [NumLanes-1:0][CodeW-1:0] luma;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign lane_en.s1 = en1;
  assign lane_en.s2 = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // lane order: top left, bottom left, top right, bottom right
  assign red   = {red_bottom_right_i, red_top_right_i,
                  red_bottom_left_i, red_top_left_i};
  assign green = {green_bottom_right_i, green_top_right_i,
                  green_bottom_left_i, green_top_left_i};
  assign blue  = {blue_bottom_right_i, blue_top_right_i,
                  blue_bottom_left_i, blue_top_left_i};

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    ryc420_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .red_i   (red[l]),
      .green_i (green[l]),
      .blue_i  (blue[l]),
      .lane_o  (lanes[l])
    );
  end

  ryc420_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en3),
    .lanes_i   (lanes),
    .luma_o    (luma),
    .cb_code_o (blue_chroma_o),
    .cr_code_o (red_chroma_o)
  );

  assign in_ready_o          = en1;
  assign out_valid_o         = v3_q;
  assign luma_top_left_o     = luma[0];
  assign luma_bottom_left_o  = luma[1];
  assign luma_top_right_o    = luma[2];
  assign luma_bottom_right_o = luma[3];

  `RYC420_ASSERT_IMPL(a_empty_s1_ready, clk_i, rst_ni, !v1_q, in_ready_o)
  `RYC420_ASSERT_NEXT(a_accept_fills_s1, clk_i, rst_ni, in_valid_i && in_ready_o, v1_q)
  `RYC420_ASSERT_NEXT(a_s2_moves_out, clk_i, rst_ni, v2_q && en3, out_valid_o)
  `RYC420_ASSERT_NEXT(a_drain_empties, clk_i, rst_ni, out_valid_o && out_ready_i && !v2_q, !out_valid_o)

endmodule

/* verif/ryc420_checker.sv */
// Result checker for the RGB to YCbCr 4:2:0 P010 converter: watches both channels,
// predicts the six codes of each accepted 2x2 block and compares them in order.
// Self-contained; instantiated beside the block by tb_rgb_to_ycbcr420_p010_top.
`timescale 1ns / 1ps

module ryc420_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [11:0][15:0] block_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [9:0]       luma_top_left_i,
  input  logic [9:0]       luma_bottom_left_i,
  input  logic [9:0]       luma_top_right_i,
  input  logic [9:0]       luma_bottom_right_i,
  input  logic [9:0]       blue_chroma_i,
  input  logic [9:0]       red_chroma_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o
);

  // Q16 coefficients, chroma offset in Q18 with the rounding half added
  localparam longint LumaR = 19595;
  localparam longint LumaG = 38470;
  localparam longint LumaB = 7471;
  localparam longint CbR   = 11058;
  localparam longint CbG   = 21710;
  localparam longint CbB   = 32768;
  localparam longint CrR   = 32768;
  localparam longint CrG   = 27439;
  localparam longint CrB   = 5329;
  localparam longint ChromaOfs = 64'sd8593999799 + 64'sd131072;
  localparam longint WordMax   = 65535;

  typedef struct packed {
    logic [3:0][9:0] luma;
    logic [9:0]      cb;
    logic [9:0]      cr;
  } ycc_codes_t;

  ycc_codes_t expected_q[$];

  function automatic logic [9:0] word_to_p010(input longint word);
    longint w;
    logic [15:0] w16;
    w = word;
    if (w < 0) w = 0;
    if (w > WordMax) w = WordMax;
    w16 = w[15:0];
    return w16[15:6];
  endfunction

  function automatic ycc_codes_t convert_block(input logic [11:0][15:0] blk);
    longint r, g, b, cb_acc, cr_acc;
    ycc_codes_t res;
    cb_acc = 0;
    cr_acc = 0;
    for (int p = 0; p < 4; p++) begin
      r = longint'(blk[3*p]);
      g = longint'(blk[3*p+1]);
      b = longint'(blk[3*p+2]);
      res.luma[p] = word_to_p010((LumaR*r + LumaG*g + LumaB*b + 32768) >>> 16);
      cb_acc += -CbR*r - CbG*g + CbB*b;
      cr_acc += CrR*r - CrG*g - CrB*b;
    end
    res.cb = word_to_p010((cb_acc + ChromaOfs) >>> 18);
    res.cr = word_to_p010((cr_acc + ChromaOfs) >>> 18);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count_o++;
    $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  initial begin
    fail_count_o = 0;
    checked_o = 0;
    pending_o = 0;
  end

  always @(posedge clk_i) begin : watch
    ycc_codes_t want, seen;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        seen.luma[0] = luma_top_left_i;
        seen.luma[1] = luma_bottom_left_i;
        seen.luma[2] = luma_top_right_i;
        seen.luma[3] = luma_bottom_right_i;
        seen.cb = blue_chroma_i;
        seen.cr = red_chroma_i;
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with no block pending", 0, 0);
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          for (int p = 0; p < 4; p++) begin
            if (seen.luma[p] !== want.luma[p])
              report_mismatch($sformatf("luma of pixel %0d (TL,BL,TR,BR)", p),
                              int'(seen.luma[p]), int'(want.luma[p]));
          end
          if (seen.cb !== want.cb)
            report_mismatch("blue_chroma", int'(seen.cb), int'(want.cb));
          if (seen.cr !== want.cr)
            report_mismatch("red_chroma", int'(seen.cr), int'(want.cr));
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(convert_block(block_i));
      pending_o <= expected_q.size();
    end
  end

endmodule

/* verif/tb_rgb_to_ycbcr420_p010_top.sv */
// Testbench top for rgb_to_ycbcr420_p010_top: drives 2x2 RGB blocks with random
// idling and back-pressure, gives the verdict from the count of ryc420_checker.
// Depends on the RTL and on verif/ryc420_checker.sv.
`timescale 1ns / 1ps

module tb_rgb_to_ycbcr420_p010_top;

  localparam int RandomItems = 1300;
  localparam int QuietFirst  = 300;
  localparam int QuietLast   = 600;
  localparam int HoldAt      = 700;
  localparam int HoldCycles  = 200;
  localparam int DrainAt     = 1000;
  localparam int IdlePct     = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid_q = 1'b0;
  logic out_ready_q = 1'b0;
  logic [11:0][15:0] block_q = '0;

  logic in_ready, out_valid;
  logic [9:0] y_tl, y_bl, y_tr, y_br, cb, cr;
  int fail_count, pending, checked;
  int sent_count = 0;
  int directed_count = 0;
  bit quiet = 1'b0;
  bit hold_done = 1'b0;

  always #4 clk = ~clk;

  // pixel p occupies entries 3p..3p+2 as R,G,B; order TL, BL, TR, BR
  rgb_to_ycbcr420_p010_top dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid_q),
    .in_ready_o          (in_ready),
    .red_top_left_i      (block_q[0]),
    .green_top_left_i    (block_q[1]),
    .blue_top_left_i     (block_q[2]),
    .red_bottom_left_i   (block_q[3]),
    .green_bottom_left_i (block_q[4]),
    .blue_bottom_left_i  (block_q[5]),
    .red_top_right_i     (block_q[6]),
    .green_top_right_i   (block_q[7]),
    .blue_top_right_i    (block_q[8]),
    .red_bottom_right_i  (block_q[9]),
    .green_bottom_right_i(block_q[10]),
    .blue_bottom_right_i (block_q[11]),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready_q),
    .luma_top_left_o     (y_tl),
    .luma_bottom_left_o  (y_bl),
    .luma_top_right_o    (y_tr),
    .luma_bottom_right_o (y_br),
    .blue_chroma_o       (cb),
    .red_chroma_o        (cr)
  );

  ryc420_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid_q),
    .in_ready_i         (in_ready),
    .block_i            (block_q),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready_q),
    .luma_top_left_i    (y_tl),
    .luma_bottom_left_i (y_bl),
    .luma_top_right_i   (y_tr),
    .luma_bottom_right_i(y_br),
    .blue_chroma_i      (cb),
    .red_chroma_i       (cr),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked)
  );

  function automatic logic [11:0][15:0] flat_colour(input logic [15:0] r, g, b);
    logic [11:0][15:0] blk;
    for (int p = 0; p < 4; p++) begin
      blk[3*p] = r;
      blk[3*p+1] = g;
      blk[3*p+2] = b;
    end
    return blk;
  endfunction

  task automatic send_block(input logic [11:0][15:0] blk);
    int gap;
    block_q <= blk;
    in_valid_q <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    gap = 0;
    if (!quiet) while ($urandom_range(99) < IdlePct) gap++;
    if (gap > 0) begin
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin : receiver
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= HoldAt) begin
        hold_done = 1'b1;
        out_ready_q <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ready_q <= quiet || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : stimulus
    logic [11:0][15:0] blk;
    int mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_block(flat_colour(16'h0000, 16'h0000, 16'h0000));
    send_block(flat_colour(16'hFFFF, 16'hFFFF, 16'hFFFF));
    for (int f = 0; f < 12; f++) begin
      blk = '0;
      blk[f] = 16'hFFFF;
      send_block(blk);
    end
    send_block(flat_colour(16'h0000, 16'h0000, 16'hFFFF)); // Cb clamps high
    send_block(flat_colour(16'hFFFF, 16'h0000, 16'h0000)); // Cr clamps high
    send_block(flat_colour(16'h0000, 16'hFFFF, 16'h0000));
    send_block(flat_colour(16'hFFFF, 16'hFFFF, 16'h0000)); // Cb near floor
    send_block(flat_colour(16'h0000, 16'hFFFF, 16'hFFFF)); // Cr near floor
    send_block(flat_colour(16'hAAAA, 16'h5555, 16'hAAAA));
    send_block(flat_colour(16'h5555, 16'hAAAA, 16'h5555));
    send_block(flat_colour(16'h8000, 16'h8000, 16'h8000));
    for (int f = 0; f < 12; f++) blk[f] = 16'(16'h1357 * (f + 1));
    send_block(blk);
    directed_count = sent_count;

    for (int i = 0; i < RandomItems; i++) begin
      quiet = (i >= QuietFirst) && (i < QuietLast);
      if (i == DrainAt) begin
        in_valid_q <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      mode = $urandom_range(99);
      for (int p = 0; p < 4; p++) begin
        for (int c = 0; c < 3; c++) begin
          if (mode < 60)
            blk[3*p+c] = 16'($urandom_range(16'hFFFF));
          else if (mode < 80)
            blk[3*p+c] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          else if (mode < 90)
            blk[3*p+c] = (c == 0) ? 16'($urandom_range(16'hFFFF)) : blk[3*p];
          else
            blk[3*p+c] = $urandom_range(1) ? 16'($urandom_range(255))
                                           : 16'(16'hFFFF - $urandom_range(255));
        end
      end
      send_block(blk);
    end
    quiet = 1'b0;
    in_valid_q <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    $display("Sent %0d blocks (%0d directed), compared %0d results.",
             sent_count, directed_count, checked);
    $display("Covered saturated, grey and random colours under idling and back-pressure.");
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
